// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the filter modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define WLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define WLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/wlp_pkg.sv =====
// ---------------------------------------------------------------------------
// wlp_pkg
// Shared types and constants of the weighted 3x3 low-pass filter
// ---------------------------------------------------------------------------
package wlp_pkg;

  localparam int MAX_WIDTH_DEF = 256;
  localparam int CFG_AW        = 2;
  localparam int CFG_DW        = 16;
  localparam int DIV_STEPS     = 8;

  localparam logic [CFG_AW-1:0] REG_CW = 2'd0;
  localparam logic [CFG_AW-1:0] REG_FW = 2'd1;
  localparam logic [CFG_AW-1:0] REG_FH = 2'd2;

  localparam logic [5:0]  CW_RESET = 6'd2;
  localparam logic [8:0]  FW_RESET = 9'd256;
  localparam logic [15:0] FH_RESET = 16'd256;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // line store read address sources
  localparam logic [1:0] RD_COL   = 2'd0;
  localparam logic [1:0] RD_LEFT  = 2'd1;
  localparam logic [1:0] RD_MID   = 2'd2;
  localparam logic [1:0] RD_RIGHT = 2'd3;

  typedef struct packed {
    logic [5:0]  cw;
    logic [8:0]  fw;
    logic [15:0] fh;
  } wlp_cfg_t;

  typedef struct packed {
    logic       ld_in;
    logic       mem_rd;
    logic [1:0] rd_sel;
    logic       pix_commit;
    logic       gather;
    logic       gsel;
    logic       dcap;
    logic [1:0] dcol;
    logic       drain_commit;
    logic       mul;
    logic       sum;
    logic       div_step;
    logic       out_load;
  } wlp_cmd_t;

  typedef struct packed {
    logic kind;
    logic done;
    logic emit0;
    logic emit1;
    logic out_full;
  } wlp_sts_t;

endpackage

// ===== sv/wlp_ctrl.sv =====
// ---------------------------------------------------------------------------
// wlp_ctrl
// Sequencer: steps each request through line store access, window update
// or drain read, then per result: multiply, sum, bit-serial divide, hand-off
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module wlp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wlp_pkg::wlp_sts_t sts,
  output wlp_pkg::wlp_cmd_t cmd
);
  import wlp_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_PRD   = 4'd2;
  localparam logic [3:0] S_PWR   = 4'd3;
  localparam logic [3:0] S_GATH  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_SUM   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_PUT   = 4'd8;
  localparam logic [3:0] S_DRD0  = 4'd9;
  localparam logic [3:0] S_DRD1  = 4'd10;
  localparam logic [3:0] S_DRD2  = 4'd11;
  localparam logic [3:0] S_DRD3  = 4'd12;

  localparam int SW = $clog2(DIV_STEPS);

  logic [3:0]    state_r, state_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic          pend_r, pend_nxt;
  logic          gsel_r, gsel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      pend_r  <= 1'b0;
      gsel_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      pend_r  <= pend_nxt;
      gsel_r  <= gsel_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    step_nxt  = step_r;
    pend_nxt  = pend_r;
    gsel_nxt  = gsel_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        // pixels after the last row and early drain ticks are dropped
        if (sts.kind == CMD_PIXEL) begin
          state_nxt = sts.done ? S_IDLE : S_PRD;
        end else begin
          state_nxt = sts.done ? S_DRD0 : S_IDLE;
        end
      end
      S_PRD: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_sel = RD_COL;
        state_nxt  = S_PWR;
      end
      S_PWR: begin
        cmd.pix_commit = 1'b1;
        if (sts.emit0) begin
          gsel_nxt  = 1'b0;
          pend_nxt  = sts.emit1;
          state_nxt = S_GATH;
        end else if (sts.emit1) begin
          gsel_nxt  = 1'b1;
          pend_nxt  = 1'b0;
          state_nxt = S_GATH;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_GATH: begin
        cmd.gather = 1'b1;
        cmd.gsel   = gsel_r;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == SW'(DIV_STEPS - 1)) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          if (pend_r) begin
            pend_nxt  = 1'b0;
            gsel_nxt  = 1'b1;
            state_nxt = S_GATH;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_DRD0: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_sel = RD_LEFT;
        state_nxt  = S_DRD1;
      end
      S_DRD1: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_sel = RD_MID;
        cmd.dcap   = 1'b1;
        cmd.dcol   = 2'd0;
        state_nxt  = S_DRD2;
      end
      S_DRD2: begin
        cmd.mem_rd = 1'b1;
        cmd.rd_sel = RD_RIGHT;
        cmd.dcap   = 1'b1;
        cmd.dcol   = 2'd1;
        state_nxt  = S_DRD3;
      end
      S_DRD3: begin
        cmd.dcap         = 1'b1;
        cmd.dcol         = 2'd2;
        cmd.drain_commit = 1'b1;
        state_nxt        = S_MUL;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `WLP_ASSERT(a_accept_to_check, in_valid && in_ready |=> state_r == S_CHECK,
    "accepted request did not move to check")
  `WLP_ASSERT(a_load_when_free, cmd.out_load |-> !sts.out_full,
    "result loaded over a pending result")
  `WLP_ASSERT(a_div_count, state_r == S_PUT |-> step_r == '0,
    "divide did not run all steps")

endmodule

// ===== sv/wlp_dp.sv =====
// ---------------------------------------------------------------------------
// wlp_dp
// Datapath: line stores, 3x3 window, counters, weighted sum, restoring
// divider and output register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module wlp_dp #(
  parameter int MAX_WIDTH = wlp_pkg::MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  wlp_pkg::wlp_cfg_t cfg,
  input  wlp_pkg::wlp_cmd_t cmd,
  output wlp_pkg::wlp_sts_t sts,
  input  logic              in_kind,
  input  logic [7:0]        in_pixel,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_pixel,
  output logic              out_last
);
  import wlp_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic [7:0] la_mem [MAX_WIDTH];
  logic [7:0] lt_mem [MAX_WIDTH];

  logic          kind_r;
  logic [7:0]    px_r;
  logic [AW-1:0] col_r, drn_r;
  logic [15:0]   row_r;
  logic [7:0]    win_r [3][3];
  logic [7:0]    la_q_r, lt_q_r;
  logic          sa_r, sb_r;
  logic [7:0]    opt_r [3];
  logic [7:0]    opm_r [3];
  logic [7:0]    opu_r [3];
  logic          last_r;
  logic [9:0]    cor_r;
  logic [15:0]   p1_r;
  logic [19:0]   p2_r;
  logic [11:0]   bsq_r;
  logic [12:0]   dd_r;
  logic [13:0]   dv_r;
  logic [21:0]   rem_r;
  logic [20:0]   dvs_r;
  logic [7:0]    q_r;
  logic          out_valid_r;
  logic [7:0]    out_pixel_r;
  logic          out_last_r;

  logic [AW-1:0] wm1, mem_addr, dl, dr;
  logic [15:0]   heff;
  logic          row_end, drn_last;
  logic [7:0]    two;
  logic [1:0]    gidx [3];
  logic [9:0]    corners, edges;
  logic [20:0]   wsum;
  logic [6:0]    bp2;
  logic [13:0]   bp2_sq;

  always_comb begin
    if (cfg.fw == 9'd0) begin
      wm1 = '0;
    end else if (int'(cfg.fw) > MAX_WIDTH) begin
      wm1 = AW'(MAX_WIDTH - 1);
    end else begin
      wm1 = AW'(cfg.fw - 9'd1);
    end
    heff     = (cfg.fh == 16'd0) ? 16'd1 : cfg.fh;
    row_end  = col_r >= wm1;
    drn_last = drn_r >= wm1;
    dl       = (drn_r != '0) ? drn_r - 1'b1 : drn_r;
    dr       = drn_last ? drn_r : drn_r + 1'b1;
    case (cmd.rd_sel)
      RD_COL:   mem_addr = col_r;
      RD_LEFT:  mem_addr = dl;
      RD_MID:   mem_addr = drn_r;
      RD_RIGHT: mem_addr = dr;
      default:  mem_addr = col_r;
    endcase
    two = (row_r >= 16'd2) ? lt_q_r : la_q_r;
    // window columns feeding the left, centre and right taps
    if (!cmd.gsel) begin
      gidx[0] = sa_r ? 2'd1 : 2'd0;
      gidx[1] = 2'd1;
      gidx[2] = 2'd2;
    end else begin
      gidx[0] = sb_r ? 2'd1 : 2'd2;
      gidx[1] = 2'd2;
      gidx[2] = 2'd2;
    end
    corners = 10'(opt_r[0]) + 10'(opt_r[2]) + 10'(opu_r[0]) + 10'(opu_r[2]);
    edges   = 10'(opt_r[1]) + 10'(opu_r[1]) + 10'(opm_r[0]) + 10'(opm_r[2]);
    wsum    = 21'(cor_r) + 21'(p1_r) + 21'(p2_r);
    bp2     = 7'(cfg.cw) + 7'd2;
    bp2_sq  = bp2 * bp2;
  end

  assign sts = '{kind:     kind_r,
                 done:     row_r >= heff,
                 emit0:    (row_r != 16'd0) && (col_r != '0),
                 emit1:    (row_r != 16'd0) && row_end,
                 out_full: out_valid_r};

  // line stores, read data registered
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      la_q_r <= la_mem[mem_addr];
      lt_q_r <= lt_mem[mem_addr];
    end
    if (cmd.pix_commit) begin
      la_mem[col_r] <= px_r;
      lt_mem[col_r] <= la_q_r;
    end
  end

  // control-side state: counters, window, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= CMD_PIXEL;
      col_r       <= '0;
      drn_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else begin
      if (cmd.ld_in) begin
        kind_r <= in_kind;
      end
      if (cmd.pix_commit) begin
        for (int i = 0; i < 3; i++) begin
          win_r[i][0] <= win_r[i][1];
          win_r[i][1] <= win_r[i][2];
        end
        win_r[0][2] <= two;
        win_r[1][2] <= la_q_r;
        win_r[2][2] <= px_r;
        if (row_end) begin
          col_r <= '0;
          row_r <= row_r + 16'd1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      if (cmd.drain_commit) begin
        if (drn_last) begin
          drn_r <= '0;
          row_r <= '0;
          col_r <= '0;
        end else begin
          drn_r <= drn_r + 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: operands, arithmetic, divider
  always_ff @(posedge clk) begin
    bsq_r <= cfg.cw * cfg.cw;
    dd_r  <= bp2_sq[12:0];
    if (cmd.ld_in) begin
      px_r <= in_pixel;
    end
    if (cmd.pix_commit) begin
      sa_r <= col_r == AW'(1);
      sb_r <= col_r != '0;
    end
    if (cmd.gather) begin
      for (int i = 0; i < 3; i++) begin
        opt_r[i] <= win_r[0][gidx[i]];
        opm_r[i] <= win_r[1][gidx[i]];
        opu_r[i] <= win_r[2][gidx[i]];
      end
      last_r <= 1'b0;
    end
    if (cmd.dcap) begin
      opm_r[cmd.dcol] <= la_q_r;
      opu_r[cmd.dcol] <= la_q_r;
      opt_r[cmd.dcol] <= (cfg.fh >= 16'd2) ? lt_q_r : la_q_r;
    end
    if (cmd.drain_commit) begin
      last_r <= drn_last;
    end
    if (cmd.mul) begin
      cor_r <= corners;
      p1_r  <= cfg.cw * edges;
      p2_r  <= bsq_r * opm_r[1];
    end
    if (cmd.sum) begin
      // round half up: (2*sum + d) / (2*d)
      rem_r <= {wsum, 1'b0} + 22'(dd_r);
      dvs_r <= {dd_r, 8'd0};
      dv_r  <= {dd_r, 1'b0};
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      if (rem_r >= 22'(dvs_r)) begin
        rem_r <= rem_r - 22'(dvs_r);
        q_r   <= {q_r[6:0], 1'b1};
      end else begin
        q_r   <= {q_r[6:0], 1'b0};
      end
      dvs_r <= dvs_r >> 1;
    end
    if (cmd.out_load) begin
      out_pixel_r <= q_r;
      out_last_r  <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_last  = out_last_r;

  `WLP_ASSERT(a_div_rem, cmd.out_load |-> rem_r < 22'(dv_r),
    "divider remainder not below divisor")
  `WLP_ASSERT(a_one_path, !(cmd.pix_commit && cmd.drain_commit),
    "pixel and drain committed together")
  `WLP_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid_r,
    "output valid after reset")

endmodule

// ===== sv/weighted_lowpass_3x3_filter_top.sv =====
// ---------------------------------------------------------------------------
// weighted_lowpass_3x3_filter_top
// Streaming 3x3 weighted low-pass filter with replicated frame borders
// ---------------------------------------------------------------------------
// Pixels enter on in_* in raster order: in_tuser low is a pixel request
// carrying in_tdata, in_tuser high is a drain tick. Results leave on out_*,
// one filtered pixel per beat, out_tlast set on the last pixel of a frame.
// Output of row r comes out while row r+1 enters; the final row comes out
// on drain ticks, one pixel per tick, after all rows have entered.
// Each request is handled in turn by the sequencer: a pixel request first
// updates the line stores and window and then yields 0, 1 or 2 results;
// a drain tick reads three line store columns and yields one result.
// Results share the one multiply/sum stage and the 8-step restoring divider.
// A finished result waits in the output register; while it is not taken
// the block keeps accepting requests until it needs to hand off the next.
// Reset clears counters and window and loads the register defaults
// (weight 2, 256 x 256); line stores hold no reset value.
// cfg_* writes are always taken; write them only while the block is idle.
// ---------------------------------------------------------------------------
module weighted_lowpass_3x3_filter_top #(
  parameter int MAX_WIDTH = wlp_pkg::MAX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] pixel_in
  input  logic                       in_tuser,   // [0] cmd
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [7:0]                 out_tdata,  // [7:0] pixel_out
  output logic                       out_tlast,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [wlp_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [wlp_pkg::CFG_DW-1:0] cfg_data
);
  import wlp_pkg::*;

  wlp_cfg_t cfg_r;
  wlp_cmd_t cmd;
  wlp_sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cw <= CW_RESET;
      cfg_r.fw <= FW_RESET;
      cfg_r.fh <= FH_RESET;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_CW:  cfg_r.cw <= cfg_data[5:0];
        REG_FW:  cfg_r.fw <= cfg_data[8:0];
        REG_FH:  cfg_r.fh <= cfg_data[15:0];
        default: cfg_r    <= cfg_r;
      endcase
    end
  end

  wlp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wlp_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .sts       (sts),
    .in_kind   (in_tuser),
    .in_pixel  (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pixel (out_tdata),
    .out_last  (out_tlast)
  );

endmodule
